[sv/sitbd_pkg.sv]
package sitbd_pkg;

  // Input word and digit array sizing
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned NUM_DIGITS  = VALUE_WIDTH;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned SUM_W       = DIGIT_W + 1;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned CNT_W       = $clog2(NUM_DIGITS + 1);
  localparam int unsigned IDX_W       = $clog2(NUM_DIGITS);
  localparam int unsigned STEP_W      = $clog2(VALUE_WIDTH);

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Base register limits
  localparam logic [DIGIT_W-1:0] BASE_MIN       = 6'd2;
  localparam logic [DIGIT_W-1:0] BASE_MAX       = 6'd36;
  localparam logic [DIGIT_W-1:0] BASE_RESET     = 6'd10;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0] CH_LETTER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS    = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_NONE     = 7'h00;

  typedef logic [VALUE_WIDTH-1:0] mag_t;

  // One classified item on its way to the converter
  typedef struct packed {
    mag_t               mag;
    logic               neg;
    logic               bad;
    logic [DIGIT_W-1:0] base;
  } job_t;

  // Digit value to '0'-'9' / 'A'-'Z'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DECIMAL_DIGITS) begin
      return CH_ZERO + dx;
    end else begin
      return CH_LETTER_A + dx - {1'b0, DECIMAL_DIGITS};
    end
  endfunction

endpackage

[sv/sitbd_front.sv]
module sitbd_front
  import sitbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [DIGIT_W-1:0]     cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output job_t                   q_job_o
);

  logic [DIGIT_W-1:0] base_q;
  logic               neg;
  mag_t               raw;

  // Base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Sign, magnitude and base check; the negation is modulo 2^W so the
  // most negative value comes out as its exact unsigned magnitude
  assign raw = value_i;
  assign neg = raw[VALUE_WIDTH-1];

  always_comb begin
    q_job_o.neg  = neg;
    q_job_o.mag  = neg ? (~raw + 1'b1) : raw;
    q_job_o.bad  = (base_q < BASE_MIN) || (base_q > BASE_MAX);
    q_job_o.base = base_q;
  end

  // Accept whenever the queue has room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

[sv/sitbd_queue.sv]
module sitbd_queue
  import sitbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[sv/sitbd_back.sv]
module sitbd_back
  import sitbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] character_o,
  output logic              last_o,
  output logic              bad_base_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_DIGIT = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_nxt;
  logic [IDX_W-1:0]   idx_q, idx_d;
  mag_t               mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [DIGIT_W-1:0] base_q, base_d;
  logic [DIGIT_W-1:0] digit_q [NUM_DIGITS];
  logic [DIGIT_W-1:0] digit_d [NUM_DIGITS];
  logic [DIGIT_W-1:0] digit_nxt [NUM_DIGITS];
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;
  logic               bad_q, bad_d;
  logic               out_free;

  logic [SUM_W-1:0]   dbl [NUM_DIGITS];
  logic [SUM_W-1:0]   sum_cell [NUM_DIGITS];
  logic [NUM_DIGITS:0] gen_v, any_v, sum_v, carry_v;

  // Digit cells: each step doubles the base-b number and adds the next
  // magnitude bit. A cell generates a carry when 2d >= b and passes one
  // through when 2d == b-1; the carries resolve as a single wide add.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dbl[i]   = {digit_q[i], 1'b0};
      gen_v[i] = (dbl[i] >= {1'b0, base_q});
      any_v[i] = gen_v[i] || ((dbl[i] | SUM_W'(1)) == {1'b0, base_q});
    end
    gen_v[NUM_DIGITS] = 1'b0;
    any_v[NUM_DIGITS] = 1'b0;
    sum_v   = any_v + gen_v + {{NUM_DIGITS{1'b0}}, mag_q[VALUE_WIDTH-1]};
    carry_v = sum_v ^ any_v ^ gen_v;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      sum_cell[i]  = dbl[i] | {{(SUM_W-1){1'b0}}, carry_v[i]};
      digit_nxt[i] = carry_v[i+1] ? DIGIT_W'(sum_cell[i] - {1'b0, base_q})
                                  : DIGIT_W'(sum_cell[i]);
    end
  end

  // Significant digit count grows when a carry reaches the first empty cell
  assign cnt_nxt = cnt_q + CNT_W'(carry_v[cnt_q]);

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  // Sequencer: load, convert, then emit sign and digits, or emit an error item for a bad base
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    base_d      = base_q;
    digit_d     = digit_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    bad_d       = bad_q;
    if (out_free) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          mag_d   = job_i.mag;
          neg_d   = job_i.neg;
          base_d  = job_i.base;
          step_d  = '0;
          cnt_d   = CNT_W'(1);
          for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_d[i] = '0;
          end
          state_d = job_i.bad ? ST_ERR : ST_CONV;
        end
      end
      ST_CONV: begin
        mag_d   = mag_q << 1;
        digit_d = digit_nxt;
        cnt_d   = cnt_nxt;
        idx_d   = IDX_W'(cnt_nxt - CNT_W'(1));
        step_d  = step_q + 1'b1;
        if (step_q == STEP_W'(VALUE_WIDTH - 1)) begin
          state_d = neg_q ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CH_MINUS;
          last_d      = 1'b0;
          bad_d       = 1'b0;
          state_d     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_char(digit_q[idx_q]);
          last_d      = (idx_q == '0);
          bad_d       = 1'b0;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CH_NONE;
          last_d      = 1'b1;
          bad_d       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      cnt_q       <= CNT_W'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    base_q  <= base_d;
    idx_q   <= idx_d;
    digit_q <= digit_d;
    char_q  <= char_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign bad_base_o  = bad_q;

`ifndef SYNTHESIS
  // No carry ever leaves the top digit cell
  a_no_top_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> !carry_v[NUM_DIGITS])
    else $error("carry out of top digit cell");

  // An error item is a single final character of zero
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && bad_q |-> last_q && (char_q == CH_NONE))
    else $error("bad base item not marked last or nonzero");

  // Emission index stays within the significant digits
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGIT |-> CNT_W'(idx_q) < cnt_q)
    else $error("digit index beyond digit count");

  // A pop always starts a conversion or an error item
  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_CONV) || (state_q == ST_ERR))
    else $error("pop did not start work");
`endif

endmodule

[sv/signed_int_to_base_digits.sv]
// Converts a signed integer to text in base 2..36, one character per cycle
// while the output is not stalled. Each item runs through a 32-step digit-cell
// conversion and then the one-character output port; the next item is taken
// only after the last character of the previous one. A bad base yields a single
// error character per item. A 2-entry queue lets input run ahead.
// Reset (async, active low) empties the queue and output; base resets to 10.
module signed_int_to_base_digits
  import sitbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [DIGIT_W-1:0]     cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CHAR_W-1:0]      character_o,
  output logic                   last_o,
  output logic                   bad_base_o
);

  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, pop_job;

  sitbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  sitbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (pop_job)
  );

  sitbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (pop_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .bad_base_o  (bad_base_o)
  );

endmodule

[bench/tb_signed_int_to_base_digits.sv]
`timescale 1ns / 100ps

module tb_signed_int_to_base_digits;
  import sitbd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // One character of converted text
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              bad_base;
  } text_char_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [DIGIT_W-1:0]     cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [VALUE_WIDTH-1:0] value_i     = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [CHAR_W-1:0]      character_o;
  logic                   last_o;
  logic                   bad_base_o;

  // Bench state
  logic [DIGIT_W-1:0]     radix = BASE_RESET;
  logic [VALUE_WIDTH-1:0] pending_values[$];
  text_char_t             expected_text[$];
  int unsigned            n_queued   = 0;
  int unsigned            n_accepted = 0;
  int unsigned            n_errors   = 0;
  int unsigned            send_gap   = 0;
  int unsigned            recv_gap   = 0;
  int unsigned            hold_left  = 0;
  int unsigned            idle_cycles = 0;
  bit                     calm          = 1'b0;
  bit                     hold_request  = 1'b0;

  signed_int_to_base_digits i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .bad_base_o  (bad_base_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Expected text of one value in the given base, sign first, MSD first; one error character for a bad base
  function automatic void queue_text(input logic [VALUE_WIDTH-1:0] value,
                                     input logic [DIGIT_W-1:0] base_val);
    logic [VALUE_WIDTH-1:0] mag;
    logic [DIGIT_W-1:0]     digit_stack[$];
    logic [DIGIT_W-1:0]     d;
    text_char_t             tc;
    if (base_val < BASE_MIN || base_val > BASE_MAX) begin
      tc = '{character: CH_NONE, last: 1'b1, bad_base: 1'b1};
      expected_text.push_back(tc);
      return;
    end
    // unsigned negate: the most negative value maps onto itself
    mag = value[VALUE_WIDTH-1] ? -value : value;
    do begin
      digit_stack.push_front(DIGIT_W'(mag % base_val));
      mag = mag / base_val;
    end while (mag != 0);
    if (value[VALUE_WIDTH-1]) begin
      tc = '{character: CH_MINUS, last: 1'b0, bad_base: 1'b0};
      expected_text.push_back(tc);
    end
    while (digit_stack.size() > 0) begin
      d = digit_stack.pop_front();
      tc.character = (d < DECIMAL_DIGITS) ? CH_ZERO + CHAR_W'(d)
                                          : CH_LETTER_A + CHAR_W'(d - DECIMAL_DIGITS);
      tc.last      = (digit_stack.size() == 0);
      tc.bad_base  = 1'b0;
      expected_text.push_back(tc);
    end
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned next_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random value: full range, small, extremes, or near a power of the base
  function automatic logic [VALUE_WIDTH-1:0] pick_value(input logic [DIGIT_W-1:0] base_val);
    int unsigned            sel;
    int unsigned            k;
    logic [VALUE_WIDTH-1:0] p;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom();
    if (sel < 7) begin
      p = $urandom_range(0, 300);
      return $urandom_range(0, 1) ? -p : p;
    end
    if (sel == 7) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return MOST_NEG;
        default: return MOST_POS;
      endcase
    end
    p = 1;
    k = $urandom_range(1, 31);
    repeat (k) begin
      if (base_val >= 2 && p <= MOST_POS / base_val) p = p * base_val;
    end
    p = p + $urandom_range(0, 2) - 1;
    return $urandom_range(0, 1) ? -p : p;
  endfunction

  task automatic offer(input logic [VALUE_WIDTH-1:0] v);
    pending_values.push_back(v);
    n_queued++;
  endtask

  // Wait until every item is in and all its text is out, then let it settle
  task automatic drain();
    do @(posedge clk_i); while (n_accepted != n_queued || expected_text.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_base(input logic [DIGIT_W-1:0] b);
    drain();
    cfg_wdata_i <= b;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radix = b;
  endtask

  // Stimulus sequencing
  initial begin
    logic [DIGIT_W-1:0] b;
    int unsigned        n_items;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // base 10 after reset
    offer('0); offer(32'd1); offer('1); offer(MOST_POS); offer(MOST_NEG);
    offer(32'd10); offer(-32'sd10); offer(32'd123456789);
    set_base(6'd2);
    offer('0); offer('1); offer(MOST_POS); offer(MOST_NEG); offer(32'd5);
    set_base(6'd36);
    offer(32'd35); offer(32'd36); offer(-32'sd35); offer(MOST_POS); offer(MOST_NEG);
    set_base(6'd16);
    offer(32'd255); offer(-32'sd256); offer(32'h0ABCDEF0);
    // out-of-range bases
    set_base(6'd0);  offer(32'd7);
    set_base(6'd1);  offer(MOST_NEG);
    set_base(6'd37); offer('1);
    set_base(6'd63); offer(32'd42);

    // random phases, first two at the legal extremes
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) b = 6'd2;
      else if (ph == 1) b = 6'd36;
      else if ($urandom_range(0, 9) < 7) b = DIGIT_W'($urandom_range(2, 36));
      else if ($urandom_range(0, 1)) b = DIGIT_W'($urandom_range(0, 1));
      else b = DIGIT_W'($urandom_range(37, 63));
      set_base(b);
      calm = (ph != 0) && ($urandom_range(0, 3) == 0);
      // long receiver hold while base-2 items pile up at the input
      if (ph == 0) hold_request = 1'b1;
      n_items = $urandom_range(18, 28);
      for (int i = 0; i < n_items; i++) offer(pick_value(b));
    end

    drain();
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Driver: offer pending items, predict text on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        queue_text(value_i, radix);
        n_accepted++;
        send_gap = next_gap();
      end
      // payload is frozen while stalled
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_values.size() > 0) begin
          value_i    <= pending_values.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each character against the oldest expectation
  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_text.size() == 0) begin
          $error("character %0h with no item pending", character_o);
          n_errors++;
        end else begin
          exp_c = expected_text.pop_front();
          if (character_o !== exp_c.character) begin
            $error("character: expected %0h, got %0h", exp_c.character, character_o);
            n_errors++;
          end
          if (last_o !== exp_c.last) begin
            $error("last: expected %0b, got %0b", exp_c.last, last_o);
            n_errors++;
          end
          if (bad_base_o !== exp_c.bad_base) begin
            $error("bad_base: expected %0b, got %0b", exp_c.bad_base, bad_base_o);
            n_errors++;
          end
        end
      end
      // stall pattern
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        recv_gap = next_gap();
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
